// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers, clocked on clk_i.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define TFWD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included.
`define TFWD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== hw/rtl/tfwd_pkg.sv =====
`timescale 1ns / 1ps
package tfwd_pkg;

  localparam int SAMPLE_BITS = 12;
  localparam int COUNT_BITS  = 16;
  localparam int CROSS_BITS  = 6;
  localparam int SUM_BITS    = 22;
  localparam int FREQ_BITS   = 16;
  localparam int COEF_BITS   = 9;
  localparam int HYS_BITS    = 12;
  localparam int PROD_BITS   = FREQ_BITS + COEF_BITS;
  localparam int QUOT_BITS   = PROD_BITS;

  localparam int MUL_STEPS   = COEF_BITS;
  localparam int DIV_STEPS   = QUOT_BITS;
  localparam int MUL_CNT_BITS = $clog2(MUL_STEPS);
  localparam int DIV_CNT_BITS = $clog2(DIV_STEPS);

  localparam logic [CROSS_BITS-1:0] CROSS_LIMIT_MAX = CROSS_BITS'(62);

  typedef enum logic [2:0] {
    REG_ZERO_LEVEL  = 3'd0,
    REG_CROSSINGS   = 3'd1,
    REG_SAMPLE_RATE = 3'd2,
    REG_BAND_LOW    = 3'd3,
    REG_BAND_HIGH   = 3'd4,
    REG_HYSTERESIS  = 3'd5,
    REG_SMOOTHING   = 3'd6
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NUM,
    ST_DIV,
    ST_SMOOTH,
    ST_BAND,
    ST_HOLD
  } state_e;

  typedef struct packed {
    logic                  fire;
    logic [CROSS_BITS-1:0] crossings;
    logic [SUM_BITS-1:0]   period_sum;
  } meas_t;

endpackage

// ===== hw/rtl/tfwd_front.sv =====
`timescale 1ns / 1ps
module tfwd_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                accept_i,
  input  logic [tfwd_pkg::SAMPLE_BITS-1:0]    sample_i,
  input  logic [tfwd_pkg::SAMPLE_BITS-1:0]    zero_level_i,
  input  logic [tfwd_pkg::CROSS_BITS-1:0]     limit_cfg_i,
  output tfwd_pkg::meas_t                     meas_o
);

  logic [tfwd_pkg::SAMPLE_BITS-1:0] prev_q;
  logic [tfwd_pkg::COUNT_BITS-1:0]  cnt_q, cnt_inc;
  logic [tfwd_pkg::CROSS_BITS-1:0]  cc_q, cc_inc, limit;
  logic [tfwd_pkg::SUM_BITS-1:0]    sum_q, sum_sat;
  logic [tfwd_pkg::SUM_BITS:0]      sum_add;
  logic                             crossed;

  always_comb begin
    cnt_inc = (cnt_q == {tfwd_pkg::COUNT_BITS{1'b1}}) ? cnt_q : cnt_q + 1'b1;
    crossed = ((prev_q > zero_level_i) && (sample_i <= zero_level_i)) ||
              ((prev_q < zero_level_i) && (sample_i >= zero_level_i));
    cc_inc  = cc_q + 1'b1;
    sum_add = {1'b0, sum_q} + (tfwd_pkg::SUM_BITS + 1)'(cnt_inc);
    sum_sat = sum_add[tfwd_pkg::SUM_BITS] ? {tfwd_pkg::SUM_BITS{1'b1}}
                                          : sum_add[tfwd_pkg::SUM_BITS-1:0];
    limit   = (limit_cfg_i > tfwd_pkg::CROSS_LIMIT_MAX) ? tfwd_pkg::CROSS_LIMIT_MAX
                                                        : limit_cfg_i;
    meas_o.fire       = crossed && (cc_inc > limit);
    meas_o.crossings  = cc_inc;
    meas_o.period_sum = sum_sat;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
      cnt_q  <= '0;
      cc_q   <= '0;
      sum_q  <= '0;
    end else if (accept_i) begin
      prev_q <= sample_i;
      if (crossed) begin
        cnt_q <= '0;
        if (meas_o.fire) begin
          cc_q  <= '0;
          sum_q <= '0;
        end else begin
          cc_q  <= cc_inc;
          sum_q <= sum_sat;
        end
      end else begin
        cnt_q <= cnt_inc;
      end
    end
  end

endmodule

// ===== hw/rtl/tfwd_mult.sv =====
`timescale 1ns / 1ps
module tfwd_mult (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [tfwd_pkg::FREQ_BITS-1:0]    mcand_i,
  input  logic [tfwd_pkg::COEF_BITS-1:0]    mplier_i,
  output logic                              done_o,
  output logic [tfwd_pkg::PROD_BITS-1:0]    product_o
);

  localparam int A = tfwd_pkg::FREQ_BITS;
  localparam int B = tfwd_pkg::COEF_BITS;

  logic [A-1:0]                      mcand_q;
  logic [A+B-1:0]                    p_q;
  logic [A:0]                        part;
  logic [tfwd_pkg::MUL_CNT_BITS-1:0] cnt_q;
  logic                              busy_q, done_q;

  // shift-add, one multiplier bit per cycle, LSB first
  assign part = {1'b0, p_q[A+B-1:B]} + {1'b0, (p_q[0] ? mcand_q : {A{1'b0}})};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == tfwd_pkg::MUL_CNT_BITS'(tfwd_pkg::MUL_STEPS - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mcand_q <= mcand_i;
      p_q     <= {{A{1'b0}}, mplier_i};
    end else if (busy_q) begin
      p_q <= {part, p_q[B-1:1]};
    end
  end

  assign done_o    = done_q;
  assign product_o = p_q;

endmodule

// ===== hw/rtl/tfwd_div.sv =====
`timescale 1ns / 1ps
module tfwd_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [tfwd_pkg::QUOT_BITS-1:0]    dividend_i,
  input  logic [tfwd_pkg::SUM_BITS-1:0]     divisor_i,
  output logic                              done_o,
  output logic [tfwd_pkg::QUOT_BITS-1:0]    quotient_o
);

  localparam int D = tfwd_pkg::SUM_BITS;
  localparam int Q = tfwd_pkg::QUOT_BITS;

  logic [D-1:0]                      div_q, rem_q, rem_d;
  logic [Q-1:0]                      q_q;
  logic [D:0]                        shifted;
  logic [D+1:0]                      trial;
  logic                              ge;
  logic [tfwd_pkg::DIV_CNT_BITS-1:0] cnt_q;
  logic                              busy_q, done_q;

  // restoring division, one quotient bit per cycle
  always_comb begin
    shifted = {rem_q, q_q[Q-1]};
    trial   = {1'b0, shifted} - {2'b00, div_q};
    ge      = !trial[D+1];
    rem_d   = ge ? trial[D-1:0] : shifted[D-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == tfwd_pkg::DIV_CNT_BITS'(tfwd_pkg::DIV_STEPS - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      div_q <= divisor_i;
      rem_q <= '0;
      q_q   <= dividend_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      q_q   <= {q_q[Q-2:0], ge};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = q_q;

endmodule

// ===== hw/rtl/tone_frequency_window_detector.sv =====
`timescale 1ns / 1ps
// Results: a sample that closes a measurement raises out_valid_o once its result is ready;
//   other samples give no result and the next one may follow in the next cycle.
// Throughput: one sample per cycle, but a closing sample holds the input while one bit-serial
//   16x9 multiplier (used twice) and a 25-step divider run and the result waits to go out.
// Reset: asynchronous, active low; registers return to defaults, counters and filter to zero.
`include "assert_macros.svh"
module tone_frequency_window_detector (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [4:0]                        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [tfwd_pkg::SAMPLE_BITS-1:0]  sample_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [tfwd_pkg::FREQ_BITS-1:0]    frequency_q4_o,
  output logic                              in_band_o
);

  localparam int F = tfwd_pkg::FREQ_BITS;
  localparam int W = F + 2;

  logic [tfwd_pkg::SAMPLE_BITS-1:0] zero_level_q;
  logic [tfwd_pkg::CROSS_BITS-1:0]  crossings_q;
  logic [F-1:0]                     rate_q, band_low_q, band_high_q;
  logic [tfwd_pkg::HYS_BITS-1:0]    hys_q;
  logic [tfwd_pkg::COEF_BITS-1:0]   smoothing_q, coef;

  tfwd_pkg::state_e state_q, state_d;
  tfwd_pkg::meas_t  meas;

  logic                           in_acc, wr, out_free;
  logic                           mul_start, mul_done, div_start, div_done;
  logic [F-1:0]                   mul_a, diff, x, y_q, y_d, out_freq_q;
  logic [tfwd_pkg::COEF_BITS-1:0] mul_b;
  logic [tfwd_pkg::PROD_BITS-1:0] product;
  logic [tfwd_pkg::QUOT_BITS-1:0] quotient;
  logic [tfwd_pkg::SUM_BITS-1:0]  sum_q;
  logic                           down, down_q, flag_q, flag_d, out_valid_q, out_flag_q;
  logic signed [W-1:0]            f, lo, hi, h;

  assign pready     = 1'b1;
  assign wr         = psel && penable && pwrite;
  assign in_stall_o = (state_q != tfwd_pkg::ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zero_level_q <= tfwd_pkg::SAMPLE_BITS'(2048);
      crossings_q  <= tfwd_pkg::CROSS_BITS'(32);
      rate_q       <= F'(5000);
      band_low_q   <= F'(1600);
      band_high_q  <= F'(4800);
      hys_q        <= tfwd_pkg::HYS_BITS'(32);
      smoothing_q  <= tfwd_pkg::COEF_BITS'(128);
    end else if (wr) begin
      unique case (paddr[4:2])
        tfwd_pkg::REG_ZERO_LEVEL:  zero_level_q <= pwdata[tfwd_pkg::SAMPLE_BITS-1:0];
        tfwd_pkg::REG_CROSSINGS:   crossings_q  <= pwdata[tfwd_pkg::CROSS_BITS-1:0];
        tfwd_pkg::REG_SAMPLE_RATE: rate_q       <= pwdata[F-1:0];
        tfwd_pkg::REG_BAND_LOW:    band_low_q   <= pwdata[F-1:0];
        tfwd_pkg::REG_BAND_HIGH:   band_high_q  <= pwdata[F-1:0];
        tfwd_pkg::REG_HYSTERESIS:  hys_q        <= pwdata[tfwd_pkg::HYS_BITS-1:0];
        tfwd_pkg::REG_SMOOTHING:   smoothing_q  <= pwdata[tfwd_pkg::COEF_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      tfwd_pkg::REG_ZERO_LEVEL:  prdata = 32'(zero_level_q);
      tfwd_pkg::REG_CROSSINGS:   prdata = 32'(crossings_q);
      tfwd_pkg::REG_SAMPLE_RATE: prdata = 32'(rate_q);
      tfwd_pkg::REG_BAND_LOW:    prdata = 32'(band_low_q);
      tfwd_pkg::REG_BAND_HIGH:   prdata = 32'(band_high_q);
      tfwd_pkg::REG_HYSTERESIS:  prdata = 32'(hys_q);
      tfwd_pkg::REG_SMOOTHING:   prdata = 32'(smoothing_q);
      default:                   prdata = '0;
    endcase
  end

  tfwd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (in_acc),
    .sample_i     (sample_i),
    .zero_level_i (zero_level_q),
    .limit_cfg_i  (crossings_q),
    .meas_o       (meas)
  );

  tfwd_mult u_mult (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (mul_start),
    .mcand_i   (mul_a),
    .mplier_i  (mul_b),
    .done_o    (mul_done),
    .product_o (product)
  );

  tfwd_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (product),
    .divisor_i  (sum_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  always_comb begin
    coef = smoothing_q[tfwd_pkg::COEF_BITS-1] ? {1'b1, {(tfwd_pkg::COEF_BITS-1){1'b0}}}
                                              : smoothing_q;
    x    = (|quotient[tfwd_pkg::QUOT_BITS-1:F]) ? {F{1'b1}} : quotient[F-1:0];
    down = (x < y_q);
    diff = down ? (y_q - x) : (x - y_q);
    // rate * crossings * 8 first, then the filter step
    if (state_q == tfwd_pkg::ST_IDLE) begin
      mul_a = rate_q;
      mul_b = {meas.crossings, 3'b000};
    end else begin
      mul_a = diff;
      mul_b = coef;
    end
    y_d = down_q ? (y_q - product[F+7:8]) : (y_q + product[F+7:8]);

    f  = W'(y_q);
    lo = W'(band_low_q);
    hi = W'(band_high_q);
    h  = W'(hys_q);
    if (flag_q) begin
      flag_d = (f >= lo - h) && (f <= hi + h);
    end else begin
      flag_d = (f >= lo + h) && (f <= hi - h);
    end
  end

  always_comb begin
    state_d   = state_q;
    mul_start = 1'b0;
    div_start = 1'b0;
    unique case (state_q)
      tfwd_pkg::ST_IDLE: begin
        if (in_acc && meas.fire) begin
          mul_start = 1'b1;
          state_d   = tfwd_pkg::ST_NUM;
        end
      end
      tfwd_pkg::ST_NUM: begin
        if (mul_done) begin
          div_start = 1'b1;
          state_d   = tfwd_pkg::ST_DIV;
        end
      end
      tfwd_pkg::ST_DIV: begin
        if (div_done) begin
          mul_start = 1'b1;
          state_d   = tfwd_pkg::ST_SMOOTH;
        end
      end
      tfwd_pkg::ST_SMOOTH: begin
        if (mul_done) begin
          state_d = tfwd_pkg::ST_BAND;
        end
      end
      tfwd_pkg::ST_BAND: state_d = tfwd_pkg::ST_HOLD;
      tfwd_pkg::ST_HOLD: begin
        if (out_free) begin
          state_d = tfwd_pkg::ST_IDLE;
        end
      end
      default: state_d = tfwd_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tfwd_pkg::ST_IDLE;
      y_q         <= '0;
      flag_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == tfwd_pkg::ST_SMOOTH && mul_done) begin
        y_q <= y_d;
      end
      if (state_q == tfwd_pkg::ST_BAND) begin
        flag_q <= flag_d;
      end
      if (state_q == tfwd_pkg::ST_HOLD && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == tfwd_pkg::ST_IDLE && in_acc && meas.fire) begin
      sum_q <= meas.period_sum;
    end
    if (state_q == tfwd_pkg::ST_DIV && div_done) begin
      down_q <= down;
    end
    if (state_q == tfwd_pkg::ST_HOLD && out_free) begin
      out_freq_q <= y_q;
      out_flag_q <= flag_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign frequency_q4_o = out_freq_q;
  assign in_band_o      = out_flag_q;

  `TFWD_ASSERT(a_mul_done_state,
    mul_done |-> (state_q == tfwd_pkg::ST_NUM || state_q == tfwd_pkg::ST_SMOOTH),
    "multiplier finished outside a multiply state")
  `TFWD_ASSERT(a_div_done_state, div_done |-> (state_q == tfwd_pkg::ST_DIV),
    "divider finished outside the divide state")
  `TFWD_ASSERT(a_out_load, (state_q == tfwd_pkg::ST_HOLD && out_free) |=>
    (out_valid_o && frequency_q4_o == $past(y_q) && in_band_o == $past(flag_q)),
    "result beat not loaded from filter state")
  `TFWD_ASSERT_ALWAYS(a_reset_idle, (!rst_ni) |=>
    (state_q == tfwd_pkg::ST_IDLE && !out_valid_o),
    "reset did not leave the block idle")

endmodule

// ===== bench/tone_frequency_window_detector_tb.sv =====
`timescale 1ns / 1ps
module tone_frequency_window_detector_tb;

  localparam int CYCLE_LIMIT   = 2_000_000;
  localparam int DRAIN_CYCLES  = 60;
  localparam int HOLD_CYCLES   = 400;
  localparam int PHASE_SAMPLES = 140;
  localparam int PHASE_RESULTS = 2;
  localparam int IDLE_OFF      = 0;
  localparam int IDLE_HEAVY    = 60;
  localparam int IDLE_SHARED   = 32;
  localparam int SAMPLE_MAX    = (1 << tfwd_pkg::SAMPLE_BITS) - 1;
  localparam logic [tfwd_pkg::SUM_BITS-1:0]   SUM_MAX = '1;
  localparam logic [tfwd_pkg::COUNT_BITS-1:0] RUN_MAX = '1;

  typedef struct packed {
    logic [tfwd_pkg::SAMPLE_BITS-1:0] zero_level;
    logic [tfwd_pkg::CROSS_BITS-1:0]  crossings;
    logic [15:0]                      rate;
    logic [tfwd_pkg::FREQ_BITS-1:0]   band_low;
    logic [tfwd_pkg::FREQ_BITS-1:0]   band_high;
    logic [tfwd_pkg::HYS_BITS-1:0]    hysteresis;
    logic [tfwd_pkg::COEF_BITS-1:0]   smoothing;
  } det_cfg_t;

  typedef struct packed {
    logic [tfwd_pkg::FREQ_BITS-1:0] frequency;
    logic                           in_band;
  } reading_t;

  logic                             clk_i = 1'b0;
  logic                             rst_ni = 1'b0;
  logic                             psel = 1'b0;
  logic                             penable = 1'b0;
  logic                             pwrite = 1'b0;
  logic [4:0]                       paddr = '0;
  logic [31:0]                      pwdata = '0;
  logic [31:0]                      prdata;
  logic                             pready;
  logic                             in_valid_i = 1'b0;
  logic                             in_stall_o;
  logic [tfwd_pkg::SAMPLE_BITS-1:0] sample_i = '0;
  logic                             out_valid_o;
  logic                             out_stall_i = 1'b0;
  logic [tfwd_pkg::FREQ_BITS-1:0]   frequency_q4_o;
  logic                             in_band_o;

  // predictor state and register shadow
  det_cfg_t                         regs = '{12'd2048, 6'd32, 16'd5000, 16'd1600, 16'd4800,
                                             12'd32, 9'd128};
  logic [tfwd_pkg::SAMPLE_BITS-1:0] last_sample = '0;
  logic [tfwd_pkg::COUNT_BITS-1:0]  run_length = '0;
  logic [tfwd_pkg::CROSS_BITS-1:0]  crossing_tally = '0;
  logic [tfwd_pkg::SUM_BITS-1:0]    period_total = '0;
  logic [tfwd_pkg::FREQ_BITS-1:0]   freq_filtered = '0;
  logic                             band_state = 1'b0;

  reading_t    pending_readings[$];
  int unsigned predicted_count = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int          tx_idle_pct = 0;
  int          rx_stall_pct = 0;
  logic        hold_req = 1'b0;
  int          hold_left = 0;

  tone_frequency_window_detector u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .sample_i       (sample_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .frequency_q4_o (frequency_q4_o),
    .in_band_o      (in_band_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // receiver stalls; a hold request forces one long stretch
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_req <= 1'b0;
      hold_left <= HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= (rx_stall_pct != 0) && ($urandom_range(99) < rx_stall_pct);
    end
  end

  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
    if (mismatch_count < 50)
      $display("mismatch on %s: expected %0d, got %0d (cycle %0d)", what, want, got,
               cycle_count);
    mismatch_count++;
  endtask

  always @(posedge clk_i) begin
    reading_t want;
    if (rst_ni && out_valid_o === 1'b1 && !out_stall_i) begin
      if (pending_readings.size() == 0) begin
        report_mismatch("unexpected beat, frequency_q4", 0, frequency_q4_o);
      end else begin
        want = pending_readings.pop_front();
        if (frequency_q4_o !== want.frequency)
          report_mismatch("frequency_q4", want.frequency, frequency_q4_o);
        if (in_band_o !== want.in_band)
          report_mismatch("in_band", want.in_band, in_band_o);
      end
    end
  end

  task automatic advance_detector(input logic [tfwd_pkg::SAMPLE_BITS-1:0] s);
    logic                             crossed;
    logic [tfwd_pkg::CROSS_BITS-1:0]  lim;
    logic [tfwd_pkg::SAMPLE_BITS-1:0] zl;
    longint unsigned                  num;
    longint unsigned                  quo;
    int unsigned                      tot;
    int unsigned                      k;
    int unsigned                      x;
    int unsigned                      y;
    int                               f;
    int                               lo;
    int                               hi;
    int                               h;
    reading_t                         r;
    zl = regs.zero_level;
    lim = (regs.crossings > tfwd_pkg::CROSS_LIMIT_MAX) ? tfwd_pkg::CROSS_LIMIT_MAX
                                                       : regs.crossings;
    if (run_length != RUN_MAX) run_length = run_length + 1'b1;
    crossed = (last_sample > zl && s <= zl) || (last_sample < zl && s >= zl);
    if (crossed) begin
      crossing_tally = crossing_tally + 1'b1;
      tot = period_total + run_length;
      period_total = (tot > SUM_MAX) ? SUM_MAX : tot[tfwd_pkg::SUM_BITS-1:0];
      if (crossing_tally > lim) begin
        num = 64'(regs.rate) * 64'(crossing_tally) * 64'd8;
        if (period_total == '0) begin
          x = 32'hFFFF;
        end else begin
          quo = num / 64'(period_total);
          x = (quo > 64'hFFFF) ? 32'hFFFF : 32'(quo);
        end
        k = (regs.smoothing > 9'd256) ? 256 : 32'(regs.smoothing);
        y = 32'(freq_filtered);
        if (x >= y) y = y + ((k * (x - y)) >> 8);
        else y = y - ((k * (y - x)) >> 8);
        freq_filtered = y[tfwd_pkg::FREQ_BITS-1:0];
        f = int'(freq_filtered);
        lo = int'(regs.band_low);
        hi = int'(regs.band_high);
        h = int'(regs.hysteresis);
        if (band_state) band_state = (f >= lo - h) && (f <= hi + h);
        else band_state = (f >= lo + h) && (f <= hi - h);
        r.frequency = freq_filtered;
        r.in_band = band_state;
        pending_readings.push_back(r);
        predicted_count++;
        crossing_tally = '0;
        period_total = '0;
      end
      run_length = '0;
    end
    last_sample = s;
  endtask

  task automatic send_sample(input logic [tfwd_pkg::SAMPLE_BITS-1:0] s);
    in_valid_i <= 1'b1;
    sample_i <= s;
    do @(posedge clk_i); while (in_stall_o);
    advance_detector(s);
    if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < tx_idle_pct);
    end
  endtask

  task automatic send_tone(input int half_len, input int halves, input int amp);
    int v;
    bit upper;
    upper = 1'($urandom_range(1));
    for (int i = 0; i < halves; i++) begin
      for (int j = 0; j < half_len; j++) begin
        v = int'(regs.zero_level) + (upper ? 1 : -1) * int'($urandom_range(amp, 1));
        if (v > SAMPLE_MAX) v = SAMPLE_MAX;
        if (v < 0) v = 0;
        send_sample(v[tfwd_pkg::SAMPLE_BITS-1:0]);
      end
      upper = !upper;
    end
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input tfwd_pkg::cfg_reg_e r, input logic [31:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {r, 2'b00};
    pwdata <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (r)
      tfwd_pkg::REG_ZERO_LEVEL:  regs.zero_level = v[tfwd_pkg::SAMPLE_BITS-1:0];
      tfwd_pkg::REG_CROSSINGS:   regs.crossings = v[tfwd_pkg::CROSS_BITS-1:0];
      tfwd_pkg::REG_SAMPLE_RATE: regs.rate = v[15:0];
      tfwd_pkg::REG_BAND_LOW:    regs.band_low = v[tfwd_pkg::FREQ_BITS-1:0];
      tfwd_pkg::REG_BAND_HIGH:   regs.band_high = v[tfwd_pkg::FREQ_BITS-1:0];
      tfwd_pkg::REG_HYSTERESIS:  regs.hysteresis = v[tfwd_pkg::HYS_BITS-1:0];
      tfwd_pkg::REG_SMOOTHING:   regs.smoothing = v[tfwd_pkg::COEF_BITS-1:0];
      default: ;
    endcase
  endtask

  task automatic load_config(input det_cfg_t c);
    write_reg(tfwd_pkg::REG_ZERO_LEVEL, 32'(c.zero_level));
    write_reg(tfwd_pkg::REG_CROSSINGS, 32'(c.crossings));
    write_reg(tfwd_pkg::REG_SAMPLE_RATE, 32'(c.rate));
    write_reg(tfwd_pkg::REG_BAND_LOW, 32'(c.band_low));
    write_reg(tfwd_pkg::REG_BAND_HIGH, 32'(c.band_high));
    write_reg(tfwd_pkg::REG_HYSTERESIS, 32'(c.hysteresis));
    write_reg(tfwd_pkg::REG_SMOOTHING, 32'(c.smoothing));
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // previous sample is zero after reset, so the first high sample crosses;
  // samples sitting on the zero line
  task automatic test_first_crossing();
    det_cfg_t c;
    c = regs;
    c.crossings = '0;
    c.smoothing = 9'd256;
    wait_idle();
    tx_idle_pct = IDLE_OFF;
    rx_stall_pct = IDLE_OFF;
    load_config(c);
    send_sample(12'd4095);
    send_sample(12'd0);
    send_sample(12'd2048);
    send_sample(12'd2048);
    send_sample(12'd4095);
    send_sample(12'd2048);
    send_sample(12'd0);
    send_sample(12'd4095);
  endtask

  // frequency saturation, zero rate, smoothing of 0, 1 and above 256, window edges
  task automatic test_extremes();
    det_cfg_t c;
    c = regs;
    c.zero_level = 12'd2048;
    c.crossings = '0;
    c.smoothing = 9'd511;
    c.rate = 16'd65535;
    c.band_low = '0;
    c.band_high = '1;
    c.hysteresis = 12'd4095;
    wait_idle();
    load_config(c);
    repeat (2) begin
      send_sample(12'd4095);
      send_sample(12'd0);
    end
    c.rate = '0;
    c.smoothing = '0;
    wait_idle();
    load_config(c);
    repeat (2) begin
      send_sample(12'd4095);
      send_sample(12'd0);
    end
    c.smoothing = 9'd1;
    c.hysteresis = '0;
    wait_idle();
    load_config(c);
    repeat (2) begin
      send_sample(12'd4095);
      send_sample(12'd0);
    end
    c.smoothing = 9'd256;
    c.hysteresis = 12'd4095;
    wait_idle();
    load_config(c);
    repeat (2) begin
      send_sample(12'd4095);
      send_sample(12'd0);
    end
  endtask

  // output held off for a long stretch while samples keep coming
  task automatic test_output_hold();
    det_cfg_t c;
    c = regs;
    c.zero_level = 12'd2048;
    c.crossings = '0;
    c.smoothing = 9'd64;
    c.rate = 16'd5000;
    c.band_low = 16'd1600;
    c.band_high = 16'd4800;
    c.hysteresis = 12'd32;
    wait_idle();
    tx_idle_pct = IDLE_OFF;
    rx_stall_pct = IDLE_OFF;
    load_config(c);
    hold_req <= 1'b1;
    send_tone(1, 40, 2047);
  endtask

  task automatic test_random_phase(input int tx, input int rx, input bit corner);
    det_cfg_t    c;
    int          lim;
    int          hp_max;
    int          center;
    int          sent;
    int unsigned base;
    int          hp;
    int          halves;
    int          amp;
    int          n;
    wait_idle();
    if (corner) begin
      case ($urandom_range(3))
        0: c.crossings = 6'd0;
        1: c.crossings = 6'd1;
        2: c.crossings = 6'd62;
        default: c.crossings = 6'd63;
      endcase
      case ($urandom_range(2))
        0: c.zero_level = '0;
        1: c.zero_level = '1;
        default: c.zero_level = 12'd2048;
      endcase
      case ($urandom_range(2))
        0: c.rate = 16'd1;
        1: c.rate = 16'd65535;
        default: c.rate = 16'($urandom_range(65535, 1));
      endcase
      case ($urandom_range(3))
        0: c.smoothing = '0;
        1: c.smoothing = 9'd1;
        2: c.smoothing = 9'd256;
        default: c.smoothing = 9'd511;
      endcase
    end else begin
      c.crossings = tfwd_pkg::CROSS_BITS'($urandom_range(8, 1));
      c.zero_level = tfwd_pkg::SAMPLE_BITS'($urandom_range(3840, 256));
      c.rate = 16'($urandom_range(20000, 1000));
      c.smoothing = tfwd_pkg::COEF_BITS'($urandom_range(256, 16));
    end
    lim = (c.crossings > tfwd_pkg::CROSS_LIMIT_MAX) ? tfwd_pkg::CROSS_LIMIT_MAX : c.crossings;
    hp_max = 40 / (lim + 1);
    if (hp_max < 1) hp_max = 1;
    if (hp_max > 20) hp_max = 20;
    if ($urandom_range(3) == 0) begin
      if (corner) begin
        c.band_low = '0;
        c.band_high = '1;
        c.hysteresis = $urandom_range(1) ? 12'd4095 : 12'd0;
      end else begin
        c.band_low = 16'($urandom_range(65535));
        c.band_high = 16'($urandom_range(65535));
        c.hysteresis = tfwd_pkg::HYS_BITS'($urandom_range(4095));
      end
    end else begin
      center = int'(c.rate) * 8 / ((hp_max + 1) / 2);
      if (center > 65535) center = 65535;
      c.band_low = 16'(center - center / 4);
      c.band_high = 16'((center + center / 4 > 65535) ? 65535 : center + center / 4);
      c.hysteresis = tfwd_pkg::HYS_BITS'((center / 8 > 4095) ? 4095
                                                              : $urandom_range(center / 8));
    end
    load_config(c);
    tx_idle_pct = tx;
    rx_stall_pct = rx;
    sent = 0;
    base = predicted_count;
    while (sent < PHASE_SAMPLES || predicted_count - base < PHASE_RESULTS) begin
      if ($urandom_range(99) < 15) begin
        n = $urandom_range(6, 1);
        repeat (n) send_sample(tfwd_pkg::SAMPLE_BITS'($urandom_range(SAMPLE_MAX)));
        sent += n;
      end else begin
        hp = $urandom_range(hp_max, 1);
        halves = $urandom_range(16, 2);
        amp = ($urandom_range(9) == 0) ? SAMPLE_MAX : $urandom_range(600, 1);
        send_tone(hp, halves, amp);
        sent += hp * halves;
      end
    end
  endtask

  task automatic test_random();
    test_random_phase(IDLE_OFF, IDLE_OFF, 1'b0);
    test_random_phase(IDLE_OFF, IDLE_OFF, 1'b1);
    test_random_phase(IDLE_HEAVY, IDLE_OFF, 1'b0);
    test_random_phase(IDLE_HEAVY, IDLE_OFF, 1'b1);
    test_random_phase(IDLE_OFF, IDLE_HEAVY, 1'b0);
    test_random_phase(IDLE_OFF, IDLE_HEAVY, 1'b1);
    test_random_phase(IDLE_SHARED, IDLE_SHARED, 1'b0);
    test_random_phase(IDLE_SHARED, IDLE_SHARED, 1'b1);
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_first_crossing();
    test_extremes();
    test_output_hold();
    test_random();
    wait_idle();
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
